// ===== hdl/alpha_blend_blitter_unit_defines.svh =====
// assertion macros used by the blitter rtl
`ifndef ALPHA_BLEND_BLITTER_UNIT_DEFINES_SVH
`define ALPHA_BLEND_BLITTER_UNIT_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define ABB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("abb check failed: same-cycle property");

// condition must hold in the cycle after the trigger
`define ABB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("abb check failed: next-cycle property");

`endif

// ===== hdl/abb_pkg.sv =====
// shared constants, types and helpers of the alpha blend blitter
`timescale 1ns / 1ps
`default_nettype none

package abb_pkg;

   localparam int FB_WIDTH  = 256;
   localparam int FB_HEIGHT = 256;
   localparam int FB_DEPTH  = FB_WIDTH * FB_HEIGHT;
   localparam int ADDR_BITS = $clog2(FB_DEPTH);
   localparam int PIX_BITS  = 24;

   localparam int REQ_DATA_BITS  = 48;
   localparam int RSP_FIELD_BITS = 50;
   localparam int RSP_DATA_BITS  = 56;
   localparam int RSP_PAD_BITS   = RSP_DATA_BITS - RSP_FIELD_BITS;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 12;

   localparam logic [7:0] CHAN_MAX  = 8'hff;
   localparam logic [8:0] VIS_RESET = 9'd256;

   typedef enum logic [2:0] {
      ST_WRITTEN,
      ST_CLIPPED,
      ST_TRANSPARENT,
      ST_BEYOND,
      ST_READ_OK,
      ST_READ_OUTSIDE
   } status_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CFG_ORIGIN_X,
      CFG_ORIGIN_Y,
      CFG_BLIT_WIDTH,
      CFG_BLIT_HEIGHT,
      CFG_VISIBLE_WIDTH,
      CFG_VISIBLE_HEIGHT
   } cfg_index_type;

   typedef struct packed {
      logic                 en;
      logic [ADDR_BITS-1:0] addr;
      logic [PIX_BITS-1:0]  data;
   } wr_type;

   // item after classification, waiting for framebuffer data
   typedef struct packed {
      status_type           status;
      logic                 we;
      logic                 rd_ok;
      logic [ADDR_BITS-1:0] addr;
      logic [7:0]           red;
      logic [7:0]           green;
      logic [7:0]           blue;
      logic [7:0]           alpha;
      logic [12:0]          dest_x;
      logic [12:0]          dest_y;
   } item_type;

   // item with channel products formed
   typedef struct packed {
      status_type           status;
      logic                 we;
      logic                 rd_ok;
      logic [ADDR_BITS-1:0] addr;
      logic [PIX_BITS-1:0]  read_pix;
      logic [15:0]          ps_r;
      logic [15:0]          ps_g;
      logic [15:0]          ps_b;
      logic [15:0]          po_r;
      logic [15:0]          po_g;
      logic [15:0]          po_b;
      logic [12:0]          dest_x;
      logic [12:0]          dest_y;
   } prod_type;

   // exact x / 255 for any x up to 255 * 255
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [15:0] t;
      t = x + {8'd0, x[15:8]} + 16'd1;
      return t[15:8];
   endfunction

endpackage

`default_nettype wire

// ===== hdl/abb_fbmem.sv =====
// framebuffer memory with one read port, one write port and a clear sweep after reset
`timescale 1ns / 1ps
`default_nettype none

module abb_fbmem (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_en,
   input  logic [abb_pkg::ADDR_BITS-1:0] rd_addr,
   output logic [abb_pkg::PIX_BITS-1:0]  rd_data,
   input  abb_pkg::wr_type               wr,
   output logic                          clearing
);
   import abb_pkg::*;

   logic [PIX_BITS-1:0]  mem [FB_DEPTH];
   logic [PIX_BITS-1:0]  rd_data_ff;
   logic                 clr_active_ff;
   logic [ADDR_BITS-1:0] clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else if (clr_active_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_BITS'(FB_DEPTH - 1)) begin
            clr_active_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clr_active_ff;

endmodule

`default_nettype wire

// ===== hdl/alpha_blend_blitter_unit.sv =====
// Alpha blend blitter: source-over blend of an RGBA stream into an RGB framebuffer.
//
// req channel: one transaction per item. req_tuser is the kind (0 blend the next
// source pixel of the blit rectangle, 1 read a stored pixel). req_tdata carries
// read_x, read_y, red, green, blue, alpha.
// rsp channel: exactly one transaction per request, in request order. rsp_tuser is
// the status, rsp_tdata carries the pixel value and the destination coordinate.
// csr channel: writes to the origin, blit size and visible size registers; each also
// restarts the blit walk at its top-left corner. Write only while the block is idle.
//
// Throughput is one item per cycle unless back-pressure or a hazard stalls it.
// The framebuffer read is issued at acceptance, the blend is written back from
// stage 2 and reads of a pending pixel are forwarded. A blend that targets a
// pixel still in flight waits until it retires. A response passes stage 1,
// stage 2 and the output register. After reset the framebuffer is cleared to
// black by a sweep (one entry per cycle); req_tready stays low until it ends,
// csr writes are taken. When rsp_tready is low the output register holds and
// the pipeline keeps filling its empty stages before req_tready drops.
`timescale 1ns / 1ps
`default_nettype none

`include "alpha_blend_blitter_unit_defines.svh"

module alpha_blend_blitter_unit (
   input  logic                               clock,
   input  logic                               reset,
   // tdata: read_x, read_y, red, green, blue, alpha
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [abb_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // tuser: kind
   input  logic                               req_tuser,
   // tdata: pixel_value, dest_x, dest_y, zero fill
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [abb_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   // tuser: status
   output logic [2:0]                         rsp_tuser,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [abb_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [abb_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import abb_pkg::*;

   // configuration and blit walk
   logic [11:0] origin_x_ff;
   logic [11:0] origin_y_ff;
   logic [11:0] blit_width_ff;
   logic [11:0] blit_height_ff;
   logic [8:0]  visible_width_ff;
   logic [8:0]  visible_height_ff;
   logic [11:0] col_ff;
   logic [11:0] row_ff;
   logic [11:0] col_in;
   logic [11:0] row_in;

   // pipeline
   logic       s1_v_ff;
   item_type   s1_ff;
   logic       s2_v_ff;
   prod_type   s2_ff;
   prod_type   s2_in;
   logic       out_v_ff;
   status_type out_status_ff;
   logic [PIX_BITS-1:0] out_pix_ff;
   logic [12:0] out_dx_ff;
   logic [12:0] out_dy_ff;

   // last pipeline write, for reads that raced it
   logic                 wb_v_ff;
   logic [ADDR_BITS-1:0] wb_addr_ff;
   logic [PIX_BITS-1:0]  wb_data_ff;

   logic adv1, adv2, adv3;
   logic accept, hazard, clearing, csr_hit, walk_step;
   logic walk_ok, rsp_beyond;
   logic [8:0]  eff_w, eff_h;
   logic [7:0]  in_rx, in_ry;
   logic [13:0] dx_full, dy_full;
   logic [12:0] col_inc;
   logic        beyond, clip;
   item_type    new_item;
   logic [PIX_BITS-1:0] mem_q, old_pix, fwd_pix, blend_pix, out_pix;
   logic [7:0]  inv_a;
   wr_type      wr;

   abb_fbmem u_fbmem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_addr  (new_item.addr),
      .rd_data  (mem_q),
      .wr       (wr),
      .clearing (clearing)
   );

   // ---------------- accept stage ----------------
   assign eff_w = (int'(visible_width_ff) > FB_WIDTH) ? 9'(FB_WIDTH) : visible_width_ff;
   assign eff_h = (int'(visible_height_ff) > FB_HEIGHT) ? 9'(FB_HEIGHT) : visible_height_ff;

   assign in_rx = req_tdata[7:0];
   assign in_ry = req_tdata[15:8];

   // true destination sums, bit 13 is the sign
   assign dx_full = {{2{origin_x_ff[11]}}, origin_x_ff} + {2'b00, col_ff};
   assign dy_full = {{2{origin_y_ff[11]}}, origin_y_ff} + {2'b00, row_ff};

   assign beyond = (blit_width_ff == '0) || (row_ff >= blit_height_ff);
   assign clip   = dx_full[13] || dy_full[13] ||
                   (dx_full[12:0] >= {4'd0, eff_w}) || (dy_full[12:0] >= {4'd0, eff_h});

   always_comb begin
      new_item.red    = req_tdata[23:16];
      new_item.green  = req_tdata[31:24];
      new_item.blue   = req_tdata[39:32];
      new_item.alpha  = req_tdata[47:40];
      new_item.we     = 1'b0;
      new_item.rd_ok  = 1'b0;
      new_item.addr   = ADDR_BITS'(dy_full[12:0]) * ADDR_BITS'(FB_WIDTH) +
                        ADDR_BITS'(dx_full[12:0]);
      new_item.dest_x = dx_full[12:0];
      new_item.dest_y = dy_full[12:0];
      if (req_tuser) begin
         new_item.addr   = ADDR_BITS'(in_ry) * ADDR_BITS'(FB_WIDTH) + ADDR_BITS'(in_rx);
         new_item.dest_x = {5'd0, in_rx};
         new_item.dest_y = {5'd0, in_ry};
         if (({1'b0, in_rx} < eff_w) && ({1'b0, in_ry} < eff_h)) begin
            new_item.status = ST_READ_OK;
            new_item.rd_ok  = 1'b1;
         end else begin
            new_item.status = ST_READ_OUTSIDE;
         end
      end else if (beyond) begin
         new_item.status = ST_BEYOND;
         new_item.dest_x = '0;
         new_item.dest_y = '0;
      end else if (clip) begin
         new_item.status = ST_CLIPPED;
      end else if (new_item.alpha == '0) begin
         new_item.status = ST_TRANSPARENT;
      end else begin
         new_item.status = ST_WRITTEN;
         new_item.we     = 1'b1;
      end
   end

   assign adv3 = !out_v_ff || rsp_tready;
   assign adv2 = !s2_v_ff || adv3;
   assign adv1 = !s1_v_ff || adv2;

   // a blend may not overtake a pending write to the same pixel
   assign hazard = new_item.we &&
                   ((s1_v_ff && s1_ff.we && (s1_ff.addr == new_item.addr)) ||
                    (s2_v_ff && s2_ff.we && (s2_ff.addr == new_item.addr)));

   assign req_tready = !clearing && adv1 && !hazard;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // ---------------- blit walk and registers ----------------
   assign walk_step = accept && !req_tuser && !beyond;
   assign col_inc   = {1'b0, col_ff} + 13'd1;
   assign csr_hit   = csr_valid && (csr_index <= CFG_VISIBLE_HEIGHT);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_hit) begin
         col_in = '0;
         row_in = '0;
      end else if (walk_step) begin
         if (col_inc >= {1'b0, blit_width_ff}) begin
            col_in = '0;
            row_in = row_ff + 12'd1;
         end else begin
            col_in = col_inc[11:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff       <= '0;
         origin_y_ff       <= '0;
         blit_width_ff     <= '0;
         blit_height_ff    <= '0;
         visible_width_ff  <= VIS_RESET;
         visible_height_ff <= VIS_RESET;
         col_ff            <= '0;
         row_ff            <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (csr_valid) begin
            case (csr_index)
               CFG_ORIGIN_X:       origin_x_ff       <= csr_data;
               CFG_ORIGIN_Y:       origin_y_ff       <= csr_data;
               CFG_BLIT_WIDTH:     blit_width_ff     <= csr_data;
               CFG_BLIT_HEIGHT:    blit_height_ff    <= csr_data;
               CFG_VISIBLE_WIDTH:  visible_width_ff  <= csr_data[8:0];
               CFG_VISIBLE_HEIGHT: visible_height_ff <= csr_data[8:0];
               default: ;
            endcase
         end
      end
   end

   // ---------------- stage 1: framebuffer data, products ----------------
   assign old_pix = (wb_v_ff && (wb_addr_ff == s1_ff.addr)) ? wb_data_ff : mem_q;
   // reads also take the write that retires in this very cycle
   assign fwd_pix = (s2_v_ff && s2_ff.we && (s2_ff.addr == s1_ff.addr)) ? blend_pix : old_pix;
   assign inv_a   = CHAN_MAX - s1_ff.alpha;

   always_comb begin
      s2_in.status   = s1_ff.status;
      s2_in.we       = s1_ff.we;
      s2_in.rd_ok    = s1_ff.rd_ok;
      s2_in.addr     = s1_ff.addr;
      s2_in.read_pix = fwd_pix;
      s2_in.ps_r     = {8'd0, s1_ff.red}   * {8'd0, s1_ff.alpha};
      s2_in.ps_g     = {8'd0, s1_ff.green} * {8'd0, s1_ff.alpha};
      s2_in.ps_b     = {8'd0, s1_ff.blue}  * {8'd0, s1_ff.alpha};
      s2_in.po_r     = {8'd0, old_pix[23:16]} * {8'd0, inv_a};
      s2_in.po_g     = {8'd0, old_pix[15:8]}  * {8'd0, inv_a};
      s2_in.po_b     = {8'd0, old_pix[7:0]}   * {8'd0, inv_a};
      s2_in.dest_x   = s1_ff.dest_x;
      s2_in.dest_y   = s1_ff.dest_y;
   end

   // ---------------- stage 2: divide, write back ----------------
   assign blend_pix = {div255(s2_ff.ps_r + s2_ff.po_r),
                       div255(s2_ff.ps_g + s2_ff.po_g),
                       div255(s2_ff.ps_b + s2_ff.po_b)};
   assign out_pix   = s2_ff.we ? blend_pix : (s2_ff.rd_ok ? s2_ff.read_pix : '0);

   assign wr.en   = s2_v_ff && s2_ff.we && adv3;
   assign wr.addr = s2_ff.addr;
   assign wr.data = blend_pix;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         wb_v_ff  <= 1'b0;
      end else begin
         if (adv1) begin
            s1_v_ff <= accept;
         end
         if (adv2) begin
            s2_v_ff <= s1_v_ff;
         end
         if (adv3) begin
            out_v_ff <= s2_v_ff;
         end
         if (wr.en) begin
            wb_v_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= new_item;
      end
      if (adv2 && s1_v_ff) begin
         s2_ff <= s2_in;
      end
      if (adv3 && s2_v_ff) begin
         out_status_ff <= s2_ff.status;
         out_pix_ff    <= out_pix;
         out_dx_ff     <= s2_ff.dest_x;
         out_dy_ff     <= s2_ff.dest_y;
      end
      if (wr.en) begin
         wb_addr_ff <= wr.addr;
         wb_data_ff <= wr.data;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tdata  = {{RSP_PAD_BITS{1'b0}}, out_dy_ff, out_dx_ff, out_pix_ff};

   // ---------------- checks ----------------
   assign walk_ok    = (row_ff <= blit_height_ff) &&
                       ((col_ff < blit_width_ff) || (col_ff == '0));
   assign rsp_beyond = rsp_tvalid && (out_status_ff == ST_BEYOND);

   `ABB_ASSERT_NOW(a_no_accept_in_clear, clock, reset, clearing, !req_tready)
   `ABB_ASSERT_NOW(a_walk_in_rect, clock, reset, 1'b1, walk_ok)
   `ABB_ASSERT_NOW(a_beyond_zero, clock, reset, rsp_beyond, rsp_tdata == '0)
   `ABB_ASSERT_NEXT(a_csr_restarts_walk, clock, reset, csr_hit, (col_ff == '0) && (row_ff == '0))

endmodule

`default_nettype wire

// ===== verif/blend_result_checker.sv =====
// response checker for the alpha blend blitter: tracks registers and pixels, predicts, compares
`timescale 1ns / 1ps

module blend_result_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [abb_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input  logic                               req_tuser,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [abb_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input  logic [2:0]                         rsp_tuser,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [abb_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [abb_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output int                                 mismatch_count,
   output int                                 outstanding
);
   import abb_pkg::*;

   localparam int DX_LSB      = PIX_BITS;
   localparam int DY_LSB      = PIX_BITS + 13;
   localparam int MAX_PRINTED = 30;

   typedef struct {
      status_type    status;
      logic [23:0]   pixel;
      logic [12:0]   dest_x;
      logic [12:0]   dest_y;
   } blit_result_type;

   logic [PIX_BITS-1:0] frame_copy [0:FB_DEPTH-1];
   logic [11:0]         col_pos;
   logic [11:0]         row_pos;
   logic signed [11:0]  org_x;
   logic signed [11:0]  org_y;
   logic [11:0]         blit_w;
   logic [11:0]         blit_h;
   logic [8:0]          vis_w;
   logic [8:0]          vis_h;
   blit_result_type     expected_results [$];
   int                  errors = 0;

   task automatic report_mismatch(input string msg);
      if (errors < MAX_PRINTED)
         $display("%0t ns mismatch: %s", $time, msg);
      errors++;
   endtask

   function automatic logic [7:0] blend_channel(input logic [7:0] src, input logic [7:0] old,
                                                input logic [7:0] a);
      int sum;
      sum = int'(src) * int'(a) + int'(old) * (int'(CHAN_MAX) - int'(a));
      return 8'(sum / int'(CHAN_MAX));
   endfunction

   function automatic void apply_register(input logic [CSR_INDEX_BITS-1:0] idx,
                                          input logic [CSR_DATA_BITS-1:0] value);
      logic known;
      known = 1'b1;
      case (idx)
         CFG_ORIGIN_X:       org_x = value;
         CFG_ORIGIN_Y:       org_y = value;
         CFG_BLIT_WIDTH:     blit_w = value;
         CFG_BLIT_HEIGHT:    blit_h = value;
         CFG_VISIBLE_WIDTH:  vis_w = value[8:0];
         CFG_VISIBLE_HEIGHT: vis_h = value[8:0];
         default:            known = 1'b0;
      endcase
      // any real register write restarts the walk at the top-left corner
      if (known) begin
         col_pos = '0;
         row_pos = '0;
      end
   endfunction

   function automatic blit_result_type predict_blit(input logic kind,
                                                    input logic [REQ_DATA_BITS-1:0] data);
      blit_result_type     res;
      logic [7:0]          rx, ry, r, g, b, a;
      logic [ADDR_BITS-1:0] addr;
      logic [PIX_BITS-1:0] old;
      int                  dx, dy, lim_w, lim_h;
      rx = data[7:0];
      ry = data[15:8];
      r  = data[23:16];
      g  = data[31:24];
      b  = data[39:32];
      a  = data[47:40];
      lim_w = (vis_w > FB_WIDTH) ? FB_WIDTH : int'(vis_w);
      lim_h = (vis_h > FB_HEIGHT) ? FB_HEIGHT : int'(vis_h);
      res.status = ST_BEYOND;
      res.pixel  = '0;
      res.dest_x = '0;
      res.dest_y = '0;
      if (kind) begin
         res.dest_x = 13'(rx);
         res.dest_y = 13'(ry);
         if (int'(rx) < lim_w && int'(ry) < lim_h) begin
            res.status = ST_READ_OK;
            res.pixel  = frame_copy[ADDR_BITS'(int'(ry) * FB_WIDTH + int'(rx))];
         end else begin
            res.status = ST_READ_OUTSIDE;
         end
      end else if (blit_w != '0 && row_pos < blit_h) begin
         // clipping works on the true sums, the reported coordinate wraps to 13 bits
         dx = int'(org_x) + int'(col_pos);
         dy = int'(org_y) + int'(row_pos);
         res.dest_x = 13'(dx);
         res.dest_y = 13'(dy);
         if (dx < 0 || dy < 0 || dx >= lim_w || dy >= lim_h) begin
            res.status = ST_CLIPPED;
         end else if (a == '0) begin
            res.status = ST_TRANSPARENT;
         end else begin
            addr = ADDR_BITS'(dy * FB_WIDTH + dx);
            old  = frame_copy[addr];
            res.pixel = {blend_channel(r, old[23:16], a), blend_channel(g, old[15:8], a),
                         blend_channel(b, old[7:0], a)};
            frame_copy[addr] = res.pixel;
            res.status = ST_WRITTEN;
         end
         col_pos = col_pos + 12'd1;
         if (col_pos >= blit_w) begin
            col_pos = '0;
            row_pos = row_pos + 12'd1;
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin : watch
      blit_result_type want;
      if (reset) begin
         for (int i = 0; i < FB_DEPTH; i++)
            frame_copy[i] = '0;
         col_pos = '0;
         row_pos = '0;
         org_x   = '0;
         org_y   = '0;
         blit_w  = '0;
         blit_h  = '0;
         vis_w   = VIS_RESET;
         vis_h   = VIS_RESET;
         expected_results.delete();
      end else begin
         if (csr_valid && csr_ready)
            apply_register(csr_index, csr_data);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("response transaction with no request outstanding");
            end else begin
               want = expected_results.pop_front();
               if (rsp_tuser !== want.status)
                  report_mismatch($sformatf("status got %0d want %0d", rsp_tuser,
                                            want.status));
               if (rsp_tdata[PIX_BITS-1:0] !== want.pixel)
                  report_mismatch($sformatf("pixel got %06h want %06h",
                                            rsp_tdata[PIX_BITS-1:0], want.pixel));
               if (rsp_tdata[DX_LSB +: 13] !== want.dest_x)
                  report_mismatch($sformatf("dest_x got %04h want %04h",
                                            rsp_tdata[DX_LSB +: 13], want.dest_x));
               if (rsp_tdata[DY_LSB +: 13] !== want.dest_y)
                  report_mismatch($sformatf("dest_y got %04h want %04h",
                                            rsp_tdata[DY_LSB +: 13], want.dest_y));
            end
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(predict_blit(req_tuser, req_tdata));
      end
      outstanding    <= expected_results.size();
      mismatch_count <= errors;
   end

endmodule

// ===== verif/tb.sv =====
// testbench top for the alpha blend blitter: stimulus, handshake idling and verdict
`timescale 1ns / 1ps

module tb;
   import abb_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int HOLD_CYCLES  = 400;
   localparam int BURST_ITEMS  = 40;
   localparam int TAIL_CYCLES  = 20;
   localparam int RANDOM_ITEMS = 1050;
   localparam int EDGE_ITEMS   = 200;
   localparam int PHASE_CAP    = 48;

   localparam logic KIND_BLEND = 1'b0;
   localparam logic KIND_READ  = 1'b1;
   localparam logic [CSR_INDEX_BITS-1:0] CFG_UNUSED = 3'd7;

   localparam logic [11:0] ORIGIN_MIN  = 12'h800;
   localparam logic [11:0] ORIGIN_MAX  = 12'h7ff;
   localparam logic [11:0] ORIGIN_EDGE = 12'd200;
   localparam logic [11:0] SIZE_MAX    = 12'hfff;
   localparam logic [11:0] VIS_FULL    = 12'h100;
   localparam logic [11:0] VIS_ABOVE   = 12'h1ff;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_BITS-1:0]  req_tdata = '0;
   logic                      req_tuser = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   logic [2:0]                rsp_tuser;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   int mismatch_count;
   int outstanding;
   int send_idle_pct = 9;
   int recv_idle_pct = 85;
   int hold_requests = 0;
   int holds_done = 0;
   int hold_left = 0;
   int cycle_count = 0;
   int blend_sent = 0;
   int read_sent = 0;
   int config_phases = 0;
   int random_sent = 0;
   // what the stimulus last programmed, used only to shape items
   int cur_vis_w = 256;
   int cur_vis_h = 256;
   int cur_blit_w = 0;
   int cur_blit_h = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   alpha_blend_blitter_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   blend_result_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   // receiver: random idling, plus long hold-offs on request
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (holds_done < hold_requests) begin
         holds_done <= holds_done + 1;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAILED: results differ");
         $finish;
      end
   end

   function automatic logic [REQ_DATA_BITS-1:0] pack_req(input logic [7:0] rx, ry, r, g, b, a);
      return {a, b, g, r, ry, rx};
   endfunction

   task automatic send_item(input logic kind, input logic [REQ_DATA_BITS-1:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      if (kind == KIND_READ)
         read_sent++;
      else
         blend_sent++;
   endtask

   task automatic send_blend(input logic [7:0] r, g, b, a);
      send_item(KIND_BLEND, pack_req(8'($urandom), 8'($urandom), r, g, b, a));
   endtask

   task automatic send_read(input logic [7:0] x, y);
      send_item(KIND_READ, pack_req(x, y, 8'($urandom), 8'($urandom), 8'($urandom),
                                    8'($urandom)));
   endtask

   function automatic logic [7:0] pick_alpha();
      case ($urandom_range(9))
         0, 1, 2: return CHAN_MAX;
         3:       return 8'd0;
         4:       return 8'd1;
         5:       return CHAN_MAX - 8'd1;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_random_blend();
      send_blend(8'($urandom), 8'($urandom), 8'($urandom), pick_alpha());
   endtask

   task automatic send_random_read();
      int lim_x, lim_y;
      lim_x = (cur_vis_w > 255) ? 255 : cur_vis_w;
      lim_y = (cur_vis_h > 255) ? 255 : cur_vis_h;
      if ($urandom_range(4) == 0)
         send_read(8'($urandom), 8'($urandom));
      else
         send_read(8'($urandom_range(lim_x)), 8'($urandom_range(lim_y)));
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      case (idx)
         CFG_BLIT_WIDTH:     cur_blit_w = int'(v);
         CFG_BLIT_HEIGHT:    cur_blit_h = int'(v);
         CFG_VISIBLE_WIDTH:  cur_vis_w = (v[8:0] > 9'd256) ? 256 : int'(v[8:0]);
         CFG_VISIBLE_HEIGHT: cur_vis_h = (v[8:0] > 9'd256) ? 256 : int'(v[8:0]);
         default: ;
      endcase
   endtask

   task automatic end_config();
      csr_valid <= 1'b0;
      @(posedge clock);
      config_phases++;
   endtask

   // stop offering and let every response come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
   endtask

   function automatic logic [11:0] pick_origin(input int span);
      case ($urandom_range(9))
         0:       return ORIGIN_MIN;
         1:       return ORIGIN_MAX;
         2:       return 12'($urandom);
         default: return 12'(int'($urandom_range(span + 12)) - 8);
      endcase
   endfunction

   function automatic logic [11:0] pick_vis();
      case ($urandom_range(7))
         0:       return 12'd0;
         1:       return 12'($urandom);
         2:       return VIS_FULL;
         3:       return 12'd1;
         default: return 12'($urandom_range(32, 4));
      endcase
   endfunction

   function automatic logic [11:0] pick_size(input int typical);
      case ($urandom_range(11))
         0:       return 12'd0;
         1:       return SIZE_MAX;
         2:       return 12'($urandom);
         default: return 12'($urandom_range(typical, 1));
      endcase
   endfunction

   task automatic random_phase();
      int wrote, n_blend, area;
      wait_drained();
      wrote = 0;
      if ($urandom_range(1)) begin write_reg(CFG_VISIBLE_WIDTH, pick_vis()); wrote++; end
      if ($urandom_range(1)) begin write_reg(CFG_VISIBLE_HEIGHT, pick_vis()); wrote++; end
      if ($urandom_range(1)) begin write_reg(CFG_BLIT_WIDTH, pick_size(10)); wrote++; end
      if ($urandom_range(1)) begin write_reg(CFG_BLIT_HEIGHT, pick_size(5)); wrote++; end
      if ($urandom_range(1)) begin write_reg(CFG_ORIGIN_X, pick_origin(cur_vis_w)); wrote++; end
      if ($urandom_range(1)) begin write_reg(CFG_ORIGIN_Y, pick_origin(cur_vis_h)); wrote++; end
      if (wrote == 0)
         write_reg(CFG_BLIT_WIDTH, pick_size(10));
      end_config();
      if (cur_blit_w == 0 || cur_blit_h == 0) begin
         n_blend = 3;
      end else begin
         area = cur_blit_w * cur_blit_h;
         // up to two items past the end of a finished rectangle that fits the phase cap
         n_blend = (area > PHASE_CAP) ? PHASE_CAP : area + $urandom_range(2);
      end
      while (n_blend > 0) begin
         if ($urandom_range(3) == 0) begin
            send_random_read();
         end else begin
            send_random_blend();
            n_blend--;
         end
         random_sent++;
      end
   endtask

   // receiver stops for a long stretch while items keep coming
   task automatic pressure_burst();
      wait_drained();
      hold_requests++;
      repeat (BURST_ITEMS) begin
         if ($urandom_range(1))
            send_random_read();
         else
            send_random_blend();
         random_sent++;
      end
   endtask

   initial begin
      bit slow_hold_done, fast_hold_done;
      slow_hold_done = 1'b0;
      fast_hold_done = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // 4x2 rectangle at the corner of the full screen
      write_reg(CFG_ORIGIN_X, 12'd0);
      write_reg(CFG_ORIGIN_Y, 12'd0);
      write_reg(CFG_BLIT_WIDTH, 12'd4);
      write_reg(CFG_BLIT_HEIGHT, 12'd2);
      write_reg(CFG_VISIBLE_WIDTH, VIS_FULL);
      write_reg(CFG_VISIBLE_HEIGHT, VIS_FULL);
      end_config();
      send_blend(CHAN_MAX, CHAN_MAX, CHAN_MAX, CHAN_MAX);
      send_blend(8'd10, 8'd20, 8'd30, 8'd0);
      send_blend(8'd200, 8'd100, 8'd50, 8'd128);
      send_blend(CHAN_MAX, 8'd0, 8'd0, 8'd1);
      send_blend(8'd0, 8'd0, 8'd0, CHAN_MAX);
      send_blend(CHAN_MAX, CHAN_MAX, CHAN_MAX, CHAN_MAX - 8'd1);
      send_blend(8'd1, 8'd2, 8'd3, CHAN_MAX);
      send_blend(8'd128, 8'd64, 8'd32, 8'd128);
      send_blend(CHAN_MAX, CHAN_MAX, CHAN_MAX, CHAN_MAX);
      send_read(8'd0, 8'd0);
      send_read(8'd2, 8'd0);
      send_read(8'd1, 8'd0);
      send_read(8'hff, 8'hff);

      // half-opaque black over the white corner pixel
      wait_drained();
      write_reg(CFG_BLIT_WIDTH, 12'd1);
      write_reg(CFG_BLIT_HEIGHT, 12'd1);
      end_config();
      send_blend(8'd0, 8'd0, 8'd0, 8'd128);
      send_read(8'd0, 8'd0);

      // origin extremes, fully off screen
      wait_drained();
      write_reg(CFG_ORIGIN_X, ORIGIN_MIN);
      write_reg(CFG_ORIGIN_Y, ORIGIN_MAX);
      write_reg(CFG_BLIT_WIDTH, 12'd2);
      end_config();
      send_blend(8'd1, 8'd1, 8'd1, CHAN_MAX);
      send_blend(8'd2, 8'd2, 8'd2, CHAN_MAX);
      send_blend(8'd3, 8'd3, 8'd3, CHAN_MAX);

      // zero visible width clips everything; an unused index changes nothing
      wait_drained();
      write_reg(CFG_ORIGIN_X, 12'd0);
      write_reg(CFG_ORIGIN_Y, 12'd0);
      write_reg(CFG_VISIBLE_WIDTH, 12'd0);
      write_reg(CFG_VISIBLE_HEIGHT, VIS_ABOVE);
      write_reg(CFG_UNUSED, SIZE_MAX);
      end_config();
      send_blend(CHAN_MAX, CHAN_MAX, CHAN_MAX, CHAN_MAX);
      send_read(8'd10, 8'd10);

      // visible size above the framebuffer acts as the framebuffer size
      wait_drained();
      write_reg(CFG_VISIBLE_WIDTH, 12'd300);
      write_reg(CFG_VISIBLE_HEIGHT, 12'd1);
      end_config();
      send_read(8'hff, 8'd0);
      send_read(8'd0, 8'd1);

      // empty rectangles
      wait_drained();
      write_reg(CFG_BLIT_WIDTH, 12'd0);
      write_reg(CFG_BLIT_HEIGHT, 12'd5);
      end_config();
      send_random_blend();
      wait_drained();
      write_reg(CFG_BLIT_WIDTH, 12'd3);
      write_reg(CFG_BLIT_HEIGHT, 12'd0);
      end_config();
      send_random_blend();

      // one long row from inside the screen past its right edge
      wait_drained();
      write_reg(CFG_VISIBLE_WIDTH, VIS_FULL);
      write_reg(CFG_VISIBLE_HEIGHT, VIS_FULL);
      write_reg(CFG_ORIGIN_X, ORIGIN_EDGE);
      write_reg(CFG_BLIT_WIDTH, SIZE_MAX);
      write_reg(CFG_BLIT_HEIGHT, SIZE_MAX);
      end_config();
      send_idle_pct = 0;
      repeat (EDGE_ITEMS) send_random_blend();

      while (random_sent < RANDOM_ITEMS) begin
         if (random_sent < RANDOM_ITEMS / 3) begin
            send_idle_pct = 9;
            recv_idle_pct = 85;
         end else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 85;
            recv_idle_pct = 9;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (!slow_hold_done && random_sent >= 100) begin
            pressure_burst();
            slow_hold_done = 1'b1;
         end
         if (!fast_hold_done && random_sent >= 2 * RANDOM_ITEMS / 3) begin
            pressure_burst();
            fast_hold_done = 1'b1;
         end
         random_phase();
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d blend and %0d read items over %0d register settings",
               blend_sent, read_sent, config_phases);
      $display("with clipping, transparency, empty and overrun rectangles, origin extremes");
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches, %0d responses missing", mismatch_count, outstanding);
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
